// ----- design/ssd_pkg.sv -----
// shared widths, constants and word types of the segment distance unit
package ssd_pkg;

  localparam int COORD_W    = 24;
  localparam int PARAM_FRAC = 16;
  localparam int PARAM_W    = PARAM_FRAC + 1;
  localparam int EPS_W      = 21;
  localparam int EPS_RESET  = 17;
  localparam int DIST_W     = 2 * COORD_W + 2;

  // internal datapath widths
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int HALF_W = SUM_W / 2;
  localparam int WIDE_W = 2 * SUM_W + 2;
  localparam int DD_W   = DIFF_W + PARAM_FRAC + 4;
  localparam int DDH_W  = (DD_W + 1) / 2;
  localparam int SQ_W   = 2 * DD_W + 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] seg1_start_x;
    logic signed [COORD_W-1:0] seg1_start_y;
    logic signed [COORD_W-1:0] seg1_start_z;
    logic signed [COORD_W-1:0] seg1_end_x;
    logic signed [COORD_W-1:0] seg1_end_y;
    logic signed [COORD_W-1:0] seg1_end_z;
    logic signed [COORD_W-1:0] seg2_start_x;
    logic signed [COORD_W-1:0] seg2_start_y;
    logic signed [COORD_W-1:0] seg2_start_z;
    logic signed [COORD_W-1:0] seg2_end_x;
    logic signed [COORD_W-1:0] seg2_end_y;
    logic signed [COORD_W-1:0] seg2_end_z;
  } ssd_in_t;

  typedef struct packed {
    logic [DIST_W-1:0]  distance_squared;
    logic [PARAM_W-1:0] param_on_first;
    logic [PARAM_W-1:0] param_on_second;
  } ssd_out_t;

endpackage

// ----- design/ssd_div.sv -----
// pipelined restoring divider giving a clamped fraction num/den in 0..1
module ssd_div #(
  parameter int NUM_W = ssd_pkg::WIDE_W,
  parameter int FRAC  = ssd_pkg::PARAM_FRAC
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [NUM_W-1:0] den,
  output logic        [FRAC:0]    quo
);

  logic [NUM_W-1:0] rem_r [FRAC];
  logic [NUM_W-1:0] den_r [FRAC];
  logic [FRAC-1:0]  q_r   [FRAC+1];
  logic             one_r [FRAC+1];

  logic [NUM_W:0]   sh      [1:FRAC];
  logic             ge      [1:FRAC];
  logic [NUM_W-1:0] rem_nxt [1:FRAC];
  logic [FRAC-1:0]  q_nxt   [1:FRAC];
  logic             num_le0;
  logic             num_ge;
  logic [NUM_W-1:0] rem0_nxt;

  always_comb begin
    num_le0  = num[NUM_W-1] || (num == '0);
    num_ge   = !num_le0 && (num >= den);
    rem0_nxt = (num_le0 || num_ge) ? '0 : num;
    for (int i = 1; i <= FRAC; i++) begin
      sh[i]      = {rem_r[i-1], 1'b0};
      ge[i]      = sh[i] >= {1'b0, den_r[i-1]};
      rem_nxt[i] = ge[i] ? NUM_W'(sh[i] - {1'b0, den_r[i-1]}) : NUM_W'(sh[i]);
      q_nxt[i]   = FRAC'({q_r[i-1], ge[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= rem0_nxt;
      den_r[0] <= den;
      q_r[0]   <= '0;
      one_r[0] <= num_ge;
      for (int i = 1; i < FRAC; i++) begin
        rem_r[i] <= rem_nxt[i];
        den_r[i] <= den_r[i-1];
      end
      for (int i = 1; i <= FRAC; i++) begin
        q_r[i]   <= q_nxt[i];
        one_r[i] <= one_r[i-1];
      end
    end
  end

  assign quo = one_r[FRAC] ? {1'b1, {FRAC{1'b0}}} : {1'b0, q_r[FRAC]};

endmodule

// ----- design/segment_segment_distance_unit.sv -----
// closest points of two 3-d segments: squared distance and clamped s, t
//
//   port group   dir  handshake          word
//   in_*         in   in_valid/in_ready  ssd_in_t, two segments, Q12.12 ends
//   out_*        out  out_valid/out_ready ssd_out_t, distance Q26.24, s, t Q1.16
//   cfg_*        in   cfg_wr_en          degenerate epsilon, 21 bits at Q26.24 scale
//
// one word enters per cycle while the output word is not held
// the pipe holds two chained 17-stage dividers (s, then t from s)
// reset is synchronous; it clears only the valid bits and loads EPS_RESET into epsilon
// a stalled output freezes the whole pipe; in_ready is the pipe advance
module segment_segment_distance_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ssd_pkg::ssd_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ssd_pkg::ssd_out_t             out_data,
  input  logic                          cfg_wr_en,
  input  logic [ssd_pkg::EPS_W-1:0]     cfg_wr_data
);
  import ssd_pkg::*;

  // stage map: 0..6 dot products and denominators, then divider for s,
  // three stages forming the t numerator, divider for t, six stages for
  // the distance, then the output register
  localparam int DIV_LAT = PARAM_FRAC + 1;
  localparam int NSTG    = 16 + 2 * DIV_LAT;
  localparam int GEO_N   = 12 + 2 * DIV_LAT;
  localparam int CTX_N   = 7 + 2 * DIV_LAT;
  localparam int SV_N    = 3 + DIV_LAT;
  localparam int ST_N    = 6;
  localparam int BS_W    = SUM_W + PARAM_W + 1;
  localparam int DS_W    = DIFF_W + PARAM_W + 1;
  localparam int HI_W    = DD_W - DDH_W;
  localparam logic [PARAM_W-1:0] PARAM_ONE = {1'b1, {PARAM_FRAC{1'b0}}};

  typedef logic signed [DIFF_W-1:0] diff_t;

  // per-axis differences, carried to the distance stages
  typedef struct packed {
    diff_t [2:0] d1;
    diff_t [2:0] d2;
    diff_t [2:0] r;
  } geo_t;

  // scalar context carried from the dot products to the final select
  typedef struct packed {
    logic                    adeg;
    logic                    edeg;
    logic        [SUM_W-1:0] a;
    logic        [SUM_W-1:0] e;
    logic signed [SUM_W-1:0] b;
    logic signed [SUM_W-1:0] f;
    logic signed [SUM_W:0]   negc;
    logic signed [SUM_W:0]   bmc;
  } ctx_t;

  // s candidates: from the joint solve, and for t clamped low or high
  typedef struct packed {
    logic [PARAM_W-1:0] s0;
    logic [PARAM_W-1:0] snc;
    logic [PARAM_W-1:0] sbc;
  } sv_t;

  typedef struct packed {
    logic [PARAM_W-1:0] s;
    logic [PARAM_W-1:0] t;
  } st_t;

  typedef struct packed {
    logic neg;
    logic gt;
  } tflag_t;

  logic              adv;
  logic [NSTG-1:0]   vld_r;
  logic              out_valid_r;
  ssd_out_t          out_data_r;
  ssd_out_t          out_nxt;
  logic [EPS_W-1:0]  eps_r;

  diff_t             p1 [3];
  diff_t             q1 [3];
  diff_t             p2 [3];
  diff_t             q2 [3];
  geo_t              geo_nxt;
  geo_t              geo_r [GEO_N];

  logic signed [PROD_W-1:0] pa_r [3];
  logic signed [PROD_W-1:0] pe_r [3];
  logic signed [PROD_W-1:0] pb_r [3];
  logic signed [PROD_W-1:0] pc_r [3];
  logic signed [PROD_W-1:0] pf_r [3];
  logic signed [SUM_W-1:0]  a3_r, e3_r, b3_r, c3_r, f3_r;

  ctx_t              ctx_nxt;
  ctx_t              ctx_r [CTX_N];
  logic [SUM_W-1:0]  babs4_r, cabs4_r, fabs4_r;
  logic              bfneg4_r, ceneg4_r;

  logic [SUM_W-1:0]  opx [4];
  logic [SUM_W-1:0]  opy [4];
  logic [SUM_W-1:0]  pp5_r [4][4];
  logic              bfneg5_r, ceneg5_r;

  logic signed [2*SUM_W:0]  ae6_r, bb6_r, bf6_r, ce6_r;
  logic signed [WIDE_W-1:0] denom7_r, snum7_r;
  logic [DIV_LAT-1:0]       dz_r;

  logic [PARAM_W-1:0] q_s1, q_snc, q_sbc, q_t;
  sv_t                sv_nxt;
  sv_t                sv_r [SV_N];
  logic signed [BS_W-1:0]   bs_r;
  logic signed [WIDE_W-1:0] tnum_r, tden_r;
  tflag_t             tf_nxt;
  tflag_t             tf_r [DIV_LAT];
  st_t                st_nxt;
  st_t                st_r [ST_N];

  logic signed [DS_W-1:0] ds_r [3];
  logic signed [DS_W-1:0] dt_r [3];
  logic signed [DD_W-1:0] dd_r [3];
  logic [DD_W-1:0]        mag_r [3];
  logic [2*DDH_W-1:0]     phh_r [3];
  logic [2*DDH_W-1:0]     phl_r [3];
  logic [2*DDH_W-1:0]     pll_r [3];
  logic [2*DD_W-1:0]      sqc_r [3];
  logic [SQ_W-1:0]        sq_tot;

  function automatic logic [SUM_W-1:0] mag_of(input logic signed [SUM_W-1:0] v);
    return v[SUM_W-1] ? SUM_W'(-v) : $unsigned(v);
  endfunction

  // reassemble a product from its four half-width partial products
  function automatic logic [2*SUM_W-1:0] join4(input logic [SUM_W-1:0] hh,
                                                input logic [SUM_W-1:0] hl,
                                                input logic [SUM_W-1:0] lh,
                                                input logic [SUM_W-1:0] ll);
    logic [2*SUM_W-1:0] w;
    w = ((2*SUM_W)'(hh) << SUM_W) + ((2*SUM_W)'(hl) << HALF_W)
      + ((2*SUM_W)'(lh) << HALF_W) + (2*SUM_W)'(ll);
    return w;
  endfunction

  function automatic logic signed [2*SUM_W:0] signed_of(input logic [2*SUM_W-1:0] m,
                                                         input logic neg);
    logic signed [2*SUM_W:0] w;
    w = $signed({1'b0, m});
    return neg ? -w : w;
  endfunction

  // whole pipe moves unless the output word is held
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // epsilon register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_W'(EPS_RESET);
    end else if (cfg_wr_en) begin
      eps_r <= cfg_wr_data;
    end
  end

  // valid bits, one per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSTG-2:0], in_valid};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  // stage 0: direction vectors and start offset
  always_comb begin
    p1[0] = DIFF_W'(in_data.seg1_start_x);
    p1[1] = DIFF_W'(in_data.seg1_start_y);
    p1[2] = DIFF_W'(in_data.seg1_start_z);
    q1[0] = DIFF_W'(in_data.seg1_end_x);
    q1[1] = DIFF_W'(in_data.seg1_end_y);
    q1[2] = DIFF_W'(in_data.seg1_end_z);
    p2[0] = DIFF_W'(in_data.seg2_start_x);
    p2[1] = DIFF_W'(in_data.seg2_start_y);
    p2[2] = DIFF_W'(in_data.seg2_start_z);
    q2[0] = DIFF_W'(in_data.seg2_end_x);
    q2[1] = DIFF_W'(in_data.seg2_end_y);
    q2[2] = DIFF_W'(in_data.seg2_end_z);
    for (int i = 0; i < 3; i++) begin
      geo_nxt.d1[i] = q1[i] - p1[i];
      geo_nxt.d2[i] = q2[i] - p2[i];
      geo_nxt.r[i]  = p1[i] - p2[i];
    end
  end

  // context from the dot-product sums, and operands of the wide multipliers
  always_comb begin
    ctx_nxt.adeg = $unsigned(a3_r) <= SUM_W'(eps_r);
    ctx_nxt.edeg = $unsigned(e3_r) <= SUM_W'(eps_r);
    ctx_nxt.a    = $unsigned(a3_r);
    ctx_nxt.e    = $unsigned(e3_r);
    ctx_nxt.b    = b3_r;
    ctx_nxt.f    = f3_r;
    ctx_nxt.negc = -(SUM_W+1)'(c3_r);
    ctx_nxt.bmc  = (SUM_W+1)'(b3_r) - (SUM_W+1)'(c3_r);
    opx[0] = ctx_r[0].a;
    opy[0] = ctx_r[0].e;
    opx[1] = babs4_r;
    opy[1] = babs4_r;
    opx[2] = babs4_r;
    opy[2] = fabs4_r;
    opx[3] = cabs4_r;
    opy[3] = ctx_r[0].e;
  end

  // stages 0..6: dot products, cross terms, denominator and s numerator
  always_ff @(posedge clk) begin
    if (adv) begin
      geo_r[0] <= geo_nxt;
      for (int i = 1; i < GEO_N; i++) begin
        geo_r[i] <= geo_r[i-1];
      end

      for (int i = 0; i < 3; i++) begin
        pa_r[i] <= $signed(geo_r[0].d1[i]) * $signed(geo_r[0].d1[i]);
        pe_r[i] <= $signed(geo_r[0].d2[i]) * $signed(geo_r[0].d2[i]);
        pb_r[i] <= $signed(geo_r[0].d1[i]) * $signed(geo_r[0].d2[i]);
        pc_r[i] <= $signed(geo_r[0].d1[i]) * $signed(geo_r[0].r[i]);
        pf_r[i] <= $signed(geo_r[0].d2[i]) * $signed(geo_r[0].r[i]);
      end

      a3_r <= SUM_W'(pa_r[0]) + SUM_W'(pa_r[1]) + SUM_W'(pa_r[2]);
      e3_r <= SUM_W'(pe_r[0]) + SUM_W'(pe_r[1]) + SUM_W'(pe_r[2]);
      b3_r <= SUM_W'(pb_r[0]) + SUM_W'(pb_r[1]) + SUM_W'(pb_r[2]);
      c3_r <= SUM_W'(pc_r[0]) + SUM_W'(pc_r[1]) + SUM_W'(pc_r[2]);
      f3_r <= SUM_W'(pf_r[0]) + SUM_W'(pf_r[1]) + SUM_W'(pf_r[2]);

      ctx_r[0] <= ctx_nxt;
      for (int i = 1; i < CTX_N; i++) begin
        ctx_r[i] <= ctx_r[i-1];
      end
      babs4_r  <= mag_of(b3_r);
      cabs4_r  <= mag_of(c3_r);
      fabs4_r  <= mag_of(f3_r);
      bfneg4_r <= b3_r[SUM_W-1] ^ f3_r[SUM_W-1];
      ceneg4_r <= c3_r[SUM_W-1];

      // wide products a*e, b*b, b*f, c*e as half-width partial products
      for (int k = 0; k < 4; k++) begin
        pp5_r[k][0] <= opx[k][SUM_W-1:HALF_W] * opy[k][SUM_W-1:HALF_W];
        pp5_r[k][1] <= opx[k][SUM_W-1:HALF_W] * opy[k][HALF_W-1:0];
        pp5_r[k][2] <= opx[k][HALF_W-1:0] * opy[k][SUM_W-1:HALF_W];
        pp5_r[k][3] <= opx[k][HALF_W-1:0] * opy[k][HALF_W-1:0];
      end
      bfneg5_r <= bfneg4_r;
      ceneg5_r <= ceneg4_r;

      ae6_r <= signed_of(join4(pp5_r[0][0], pp5_r[0][1], pp5_r[0][2], pp5_r[0][3]), 1'b0);
      bb6_r <= signed_of(join4(pp5_r[1][0], pp5_r[1][1], pp5_r[1][2], pp5_r[1][3]), 1'b0);
      bf6_r <= signed_of(join4(pp5_r[2][0], pp5_r[2][1], pp5_r[2][2], pp5_r[2][3]),
                         bfneg5_r);
      ce6_r <= signed_of(join4(pp5_r[3][0], pp5_r[3][1], pp5_r[3][2], pp5_r[3][3]),
                         ceneg5_r);

      denom7_r <= WIDE_W'(ae6_r) - WIDE_W'(bb6_r);
      snum7_r  <= WIDE_W'(bf6_r) - WIDE_W'(ce6_r);

      // parallel segments force s to zero, tracked beside the divider
      dz_r <= {dz_r[DIV_LAT-2:0], denom7_r == '0};
    end
  end

  // s from the joint solve, and s for t clamped at 0 or at 1
  ssd_div #(.NUM_W(WIDE_W), .FRAC(PARAM_FRAC)) u_div_s (
    .clk (clk),
    .en  (adv),
    .num (snum7_r),
    .den (denom7_r),
    .quo (q_s1)
  );

  ssd_div #(.NUM_W(WIDE_W), .FRAC(PARAM_FRAC)) u_div_snc (
    .clk (clk),
    .en  (adv),
    .num (WIDE_W'($signed(ctx_r[3].negc))),
    .den ($signed(WIDE_W'(ctx_r[3].a))),
    .quo (q_snc)
  );

  ssd_div #(.NUM_W(WIDE_W), .FRAC(PARAM_FRAC)) u_div_sbc (
    .clk (clk),
    .en  (adv),
    .num (WIDE_W'($signed(ctx_r[3].bmc))),
    .den ($signed(WIDE_W'(ctx_r[3].a))),
    .quo (q_sbc)
  );

  // t numerator is b*s + f<<frac over e<<frac; a point first segment gives s = 0
  always_comb begin
    sv_nxt.s0  = (ctx_r[3+DIV_LAT].adeg || dz_r[DIV_LAT-1]) ? '0 : q_s1;
    sv_nxt.snc = q_snc;
    sv_nxt.sbc = q_sbc;
    tf_nxt.neg = tnum_r[WIDE_W-1];
    tf_nxt.gt  = tnum_r > tden_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sv_r[0] <= sv_nxt;
      for (int i = 1; i < SV_N; i++) begin
        sv_r[i] <= sv_r[i-1];
      end
      bs_r   <= $signed(ctx_r[4+DIV_LAT].b) * $signed({1'b0, sv_r[0].s0});
      tnum_r <= WIDE_W'(bs_r) + (WIDE_W'($signed(ctx_r[5+DIV_LAT].f)) <<< PARAM_FRAC);
      tden_r <= $signed(WIDE_W'(ctx_r[5+DIV_LAT].e) << PARAM_FRAC);
      tf_r[0] <= tf_nxt;
      for (int i = 1; i < DIV_LAT; i++) begin
        tf_r[i] <= tf_r[i-1];
      end
    end
  end

  ssd_div #(.NUM_W(WIDE_W), .FRAC(PARAM_FRAC)) u_div_t (
    .clk (clk),
    .en  (adv),
    .num (tnum_r),
    .den (tden_r),
    .quo (q_t)
  );

  // final choice of s and t by case
  always_comb begin
    st_nxt.s = '0;
    st_nxt.t = '0;
    if (ctx_r[6+2*DIV_LAT].adeg && ctx_r[6+2*DIV_LAT].edeg) begin
      st_nxt.s = '0;
      st_nxt.t = '0;
    end else if (ctx_r[6+2*DIV_LAT].adeg) begin
      st_nxt.s = '0;
      st_nxt.t = q_t;
    end else if (ctx_r[6+2*DIV_LAT].edeg) begin
      st_nxt.s = sv_r[2+DIV_LAT].snc;
      st_nxt.t = '0;
    end else if (tf_r[DIV_LAT-1].neg) begin
      st_nxt.s = sv_r[2+DIV_LAT].snc;
      st_nxt.t = '0;
    end else if (tf_r[DIV_LAT-1].gt) begin
      st_nxt.s = sv_r[2+DIV_LAT].sbc;
      st_nxt.t = PARAM_ONE;
    end else begin
      st_nxt.s = sv_r[2+DIV_LAT].s0;
      st_nxt.t = q_t;
    end
  end

  // distance: dd = r<<frac + d1*s - d2*t per axis, squared in halves
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= st_nxt;
      for (int i = 1; i < ST_N; i++) begin
        st_r[i] <= st_r[i-1];
      end
      for (int i = 0; i < 3; i++) begin
        ds_r[i]  <= $signed(geo_r[10+2*DIV_LAT].d1[i]) * $signed({1'b0, st_r[0].s});
        dt_r[i]  <= $signed(geo_r[10+2*DIV_LAT].d2[i]) * $signed({1'b0, st_r[0].t});
        dd_r[i]  <= (DD_W'($signed(geo_r[11+2*DIV_LAT].r[i])) <<< PARAM_FRAC)
                  + DD_W'(ds_r[i]) - DD_W'(dt_r[i]);
        mag_r[i] <= dd_r[i][DD_W-1] ? DD_W'(-dd_r[i]) : $unsigned(dd_r[i]);
        phh_r[i] <= HI_W'(mag_r[i][DD_W-1:DDH_W]) * HI_W'(mag_r[i][DD_W-1:DDH_W]);
        phl_r[i] <= HI_W'(mag_r[i][DD_W-1:DDH_W]) * mag_r[i][DDH_W-1:0];
        pll_r[i] <= mag_r[i][DDH_W-1:0] * mag_r[i][DDH_W-1:0];
        sqc_r[i] <= ((2*DD_W)'(phh_r[i]) << (2*DDH_W))
                  + ((2*DD_W)'(phl_r[i]) << (DDH_W+1))
                  + (2*DD_W)'(pll_r[i]);
      end
    end
  end

  // sum of squares, round half up back to Q26.24
  always_comb begin
    sq_tot = SQ_W'(sqc_r[0]) + SQ_W'(sqc_r[1]) + SQ_W'(sqc_r[2])
           + (SQ_W'(1) << (2*PARAM_FRAC-1));
    out_nxt.distance_squared = sq_tot[2*PARAM_FRAC +: DIST_W];
    out_nxt.param_on_first   = st_r[ST_N-1].s;
    out_nxt.param_on_second  = st_r[ST_N-1].t;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.param_on_first <= PARAM_ONE &&
                   out_data.param_on_second <= PARAM_ONE))
    else $error("parameter above one");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipe moved while output held");

  a_word_entered: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted word lost at entry");
`endif

endmodule

// ----- bench/segment_segment_distance_checker.sv -----
// checker for the segment distance unit: predicts each word and compares results
module segment_segment_distance_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  ssd_pkg::ssd_in_t           in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  ssd_pkg::ssd_out_t          out_data,
  input  logic                       cfg_wr_en,
  input  logic [ssd_pkg::EPS_W-1:0]  cfg_wr_data,
  output int                         fail_count,
  output int                         pending_count
);
  import ssd_pkg::*;

  localparam logic [PARAM_W-1:0] ONE = 1 << PARAM_FRAC;

  logic [EPS_W-1:0] eps_q;
  ssd_out_t         expected_q[$];

  assign pending_count = expected_q.size();

  // clamp(num/den) to 0..1 in Q1.16, truncated; den > 0
  function automatic logic [PARAM_W-1:0] clamp_quot(logic signed [127:0] num,
                                                    logic signed [127:0] den);
    logic signed [127:0] q;
    if (num <= 0) return '0;
    if (num >= den) return ONE;
    q = (num <<< PARAM_FRAC) / den;
    return q[PARAM_W-1:0];
  endfunction

  function automatic ssd_out_t closest_pair(ssd_in_t w, logic [EPS_W-1:0] eps);
    logic signed [63:0]  p1[3], q1[3], p2[3], q2[3], d1[3], d2[3], rr[3];
    logic signed [63:0]  a, e, b, c, f, eps_s, dd;
    logic signed [127:0] denom, tnum, tden, acc;
    logic [PARAM_W-1:0]  s, t;
    ssd_out_t            res;
    p1 = '{w.seg1_start_x, w.seg1_start_y, w.seg1_start_z};
    q1 = '{w.seg1_end_x, w.seg1_end_y, w.seg1_end_z};
    p2 = '{w.seg2_start_x, w.seg2_start_y, w.seg2_start_z};
    q2 = '{w.seg2_end_x, w.seg2_end_y, w.seg2_end_z};
    a = 0; e = 0; b = 0; c = 0; f = 0; s = '0; t = '0;
    for (int i = 0; i < 3; i++) begin
      d1[i] = q1[i] - p1[i];
      d2[i] = q2[i] - p2[i];
      rr[i] = p1[i] - p2[i];
      a += d1[i] * d1[i];
      e += d2[i] * d2[i];
      b += d1[i] * d2[i];
      c += d1[i] * rr[i];
      f += d2[i] * rr[i];
    end
    eps_s = {43'd0, eps};
    if (a <= eps_s && e <= eps_s) begin
      acc = rr[0] * rr[0] + rr[1] * rr[1] + rr[2] * rr[2];
      res.distance_squared = acc[DIST_W-1:0];
    end else begin
      if (a <= eps_s) begin
        t = clamp_quot(f, e);
      end else if (e <= eps_s) begin
        s = clamp_quot(-c, a);
      end else begin
        denom = 128'(a) * e - 128'(b) * b;
        if (denom != 0) s = clamp_quot(128'(b) * f - 128'(c) * e, denom);
        tnum = 128'(b) * $signed({1'b0, s}) + (128'(f) <<< PARAM_FRAC);
        tden = 128'(e) <<< PARAM_FRAC;
        if (tnum < 0) begin
          s = clamp_quot(-c, a);
        end else if (tnum > tden) begin
          t = ONE;
          s = clamp_quot(b - c, a);
        end else begin
          t = clamp_quot(tnum, tden);
        end
      end
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        dd = (rr[i] <<< PARAM_FRAC) + d1[i] * $signed({1'b0, s})
             - d2[i] * $signed({1'b0, t});
        acc += 128'(dd) * dd;
      end
      // round half up from Q26.56 to Q26.24
      acc = (acc + (128'sd1 <<< (2 * PARAM_FRAC - 1))) >>> (2 * PARAM_FRAC);
      res.distance_squared = acc[DIST_W-1:0];
    end
    res.param_on_first  = s;
    res.param_on_second = t;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      eps_q      <= EPS_W'(EPS_RESET);
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) eps_q <= cfg_wr_data;
      if (in_valid && in_ready) expected_q.push_back(closest_pair(in_data, eps_q));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          ssd_out_t x;
          x = expected_q.pop_front();
          if (x.distance_squared !== out_data.distance_squared) begin
            $error("distance_squared exp %0d got %0d", x.distance_squared,
                   out_data.distance_squared);
            fail_count <= fail_count + 1;
          end
          if (x.param_on_first !== out_data.param_on_first) begin
            $error("param_on_first exp %0d got %0d", x.param_on_first,
                   out_data.param_on_first);
            fail_count <= fail_count + 1;
          end
          if (x.param_on_second !== out_data.param_on_second) begin
            $error("param_on_second exp %0d got %0d", x.param_on_second,
                   out_data.param_on_second);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- bench/segment_segment_distance_unit_tb.sv -----
// testbench top: stimulus, configuration phases and verdict for the segment distance unit
module segment_segment_distance_unit_tb;
  import ssd_pkg::*;

  localparam int LATENCY   = 51;
  localparam int CYCLE_CAP = 400000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  ssd_in_t          in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  ssd_out_t         out_data;
  logic             cfg_wr_en = 1'b0;
  logic [EPS_W-1:0] cfg_wr_data = '0;
  int               fail_count;
  int               pending_count;
  int               cycle_count = 0;
  logic             stim_done = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  segment_segment_distance_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  segment_segment_distance_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("segment_segment_distance_unit: mismatch");
      $finish;
    end
  end

  // result side: random stall drawn per word, often none
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      out_ready <= 1'b0;
      repeat (gap) @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // coordinate generator: full range, small near values, extremes, or moderate values about zero
  function automatic logic [COORD_W-1:0] pick_coord(logic [COORD_W-1:0] near);
    case ($urandom_range(0, 5))
      0: return COORD_W'($urandom);
      1: return near + COORD_W'($signed($urandom_range(0, 64)) - 32);
      2: return near + COORD_W'($signed($urandom_range(0, 16384)) - 8192);
      3: return $urandom_range(0, 1) ? {1'b1, {(COORD_W-1){1'b0}}}
                                     : {1'b0, {(COORD_W-1){1'b1}}};
      default: return COORD_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic ssd_in_t random_word();
    ssd_in_t w;
    logic [COORD_W-1:0] base;
    base = COORD_W'($urandom);
    w.seg1_start_x = pick_coord(base); w.seg1_start_y = pick_coord(base);
    w.seg1_start_z = pick_coord(base);
    // often make segment one short or degenerate, or parallel to segment two
    w.seg1_end_x = pick_coord(w.seg1_start_x); w.seg1_end_y = pick_coord(w.seg1_start_y);
    w.seg1_end_z = pick_coord(w.seg1_start_z);
    if ($urandom_range(0, 9) == 0) begin
      w.seg1_end_x = w.seg1_start_x; w.seg1_end_y = w.seg1_start_y;
      w.seg1_end_z = w.seg1_start_z;
    end
    w.seg2_start_x = pick_coord(base); w.seg2_start_y = pick_coord(base);
    w.seg2_start_z = pick_coord(base);
    w.seg2_end_x = pick_coord(w.seg2_start_x); w.seg2_end_y = pick_coord(w.seg2_start_y);
    w.seg2_end_z = pick_coord(w.seg2_start_z);
    case ($urandom_range(0, 9))
      0: begin
        w.seg2_end_x = w.seg2_start_x; w.seg2_end_y = w.seg2_start_y;
        w.seg2_end_z = w.seg2_start_z;
      end
      1: begin
        // parallel: same direction vector, small offsets to stay in range
        w.seg1_start_x = COORD_W'($signed($urandom_range(0, 4096)) - 2048);
        w.seg1_start_y = COORD_W'($signed($urandom_range(0, 4096)) - 2048);
        w.seg1_start_z = COORD_W'($signed($urandom_range(0, 4096)) - 2048);
        w.seg1_end_x = w.seg1_start_x + 24'd1000; w.seg1_end_y = w.seg1_start_y - 24'd300;
        w.seg1_end_z = w.seg1_start_z + 24'd77;
        w.seg2_end_x = w.seg2_start_x + 24'd1000; w.seg2_end_y = w.seg2_start_y - 24'd300;
        w.seg2_end_z = w.seg2_start_z + 24'd77;
      end
      default: ;
    endcase
    return w;
  endfunction

  // present one word and hold it until accepted
  task automatic send_word(ssd_in_t w, bit with_gap);
    int gap;
    gap = with_gap ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // idle the input, drain all results, then let the pipe settle
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_epsilon(logic [EPS_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  ssd_in_t w;
  logic [EPS_W-1:0] eps_pick[5] = '{21'd0, 21'd17, 21'd1048576, 21'd4096, 21'd1};

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed words at the reset epsilon
    w = '0;                                             // both degenerate at origin
    send_word(w, 1'b0);
    w = '{default: {1'b1, 23'd0}};                      // all minimum
    send_word(w, 1'b0);
    w = '{default: {1'b0, {23{1'b1}}}};                 // all maximum
    send_word(w, 1'b0);
    w = '0;                                             // opposite corners, degenerate
    w.seg1_start_x = {1'b1, 23'd0}; w.seg1_end_x = {1'b1, 23'd0};
    w.seg2_start_x = {1'b0, {23{1'b1}}}; w.seg2_end_x = {1'b0, {23{1'b1}}};
    w.seg1_start_y = {1'b1, 23'd0}; w.seg1_end_y = {1'b1, 23'd0};
    w.seg2_start_z = {1'b0, {23{1'b1}}}; w.seg2_end_z = {1'b0, {23{1'b1}}};
    send_word(w, 1'b0);
    w = '0; w.seg1_end_x = 24'd4096; w.seg2_start_y = 24'd4096;   // first only real
    w.seg2_end_y = 24'd4096; send_word(w, 1'b0);
    w = '0; w.seg2_end_y = 24'd4096; w.seg1_start_x = 24'd2048;    // second only real
    w.seg1_end_x = 24'd2048; send_word(w, 1'b0);
    w = '0; w.seg1_end_x = 24'd4096; w.seg2_start_y = 24'd4096;    // parallel
    w.seg2_end_x = 24'd4096; w.seg2_end_y = 24'd4096; send_word(w, 1'b0);
    w = '0; w.seg1_end_x = 24'd4096; w.seg2_start_x = 24'd2048;    // crossing
    w.seg2_start_y = -24'sd4096; w.seg2_end_x = 24'd2048; w.seg2_end_y = 24'd4096;
    w.seg2_start_z = 24'd100; w.seg2_end_z = 24'd100; send_word(w, 1'b0);
    w = '0; w.seg1_end_x = 24'd4096; w.seg2_start_x = 24'd8192;    // t below zero
    w.seg2_end_x = 24'd12288; w.seg2_end_y = 24'd4096; send_word(w, 1'b0);
    w = '0; w.seg1_end_x = 24'd4096; w.seg2_start_x = -24'sd8192;  // s below zero
    w.seg2_start_y = 24'd4096; w.seg2_end_x = -24'sd4096; w.seg2_end_y = 24'd8192;
    send_word(w, 1'b0);
    w = '0; w.seg1_end_x = 24'd4; w.seg2_start_y = 24'd4096;       // tiny, near epsilon
    w.seg2_end_y = 24'd4100; send_word(w, 1'b0);
    for (int k = 0; k < 8; k++) send_word(random_word(), 1'b1);

    // sender pauses until every result is back
    drain_pipe();

    // random phases over several epsilon settings, zero included
    for (int ph = 0; ph < 6; ph++) begin
      write_epsilon(ph < 5 ? eps_pick[ph] : EPS_W'($urandom_range(0, 1048576)));
      for (int k = 0; k < 305; k++)
        send_word(random_word(), ($urandom_range(0, 4) != 0) && ((k / 60) % 2 == 0));
      drain_pipe();
    end

    stim_done <= 1'b1;
    if (fail_count == 0) begin
      $display("segment_segment_distance_unit: match");
    end else begin
      $display("segment_segment_distance_unit: mismatch");
    end
    $finish;
  end
endmodule

// ----- files.f -----
design/ssd_pkg.sv
design/ssd_div.sv
design/segment_segment_distance_unit.sv
bench/segment_segment_distance_checker.sv
bench/segment_segment_distance_unit_tb.sv
